[rtl/sgt_pkg.sv]
`default_nettype none

package sgt_pkg;

  localparam int STROKE_BYTE_BITS = 8;
  localparam int PLACE_BITS       = 16;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 16;
  localparam int SCALE_BITS       = 16;
  localparam int TRIG_BITS        = 16;
  localparam int TRIG_FRAC_BITS   = 14;

  // Q2.14 unity, used as cosine when rotation is off
  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = 16'sd16384;
  localparam logic [SCALE_BITS-1:0]       SCALE_RESET = 16'd256;

  typedef enum logic {
    REQ_PLACE  = 1'b0,
    REQ_STROKE = 1'b1
  } req_type_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TEXT_DIRECTION = 3'd0,
    CFG_SCALE_X        = 3'd1,
    CFG_SCALE_Y        = 3'd2,
    CFG_ROTATE_ENABLE  = 3'd3,
    CFG_COS_ANGLE      = 3'd4,
    CFG_SIN_ANGLE      = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_DIFF,
    ST_ROT_X0,
    ST_ROT_X1,
    ST_ROT_Y0,
    ST_ROT_Y1,
    ST_EMIT
  } sgt_state_t;

endpackage

`default_nettype wire

[rtl/sgt_if.sv]
`default_nettype none

interface sgt_in_if
  import sgt_pkg::*;
();
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic        [STROKE_BYTE_BITS-1:0] stroke_x_byte;
  logic        [STROKE_BYTE_BITS-1:0] stroke_y_byte;
  logic signed [PLACE_BITS-1:0]       place_x;
  logic signed [PLACE_BITS-1:0]       place_y;

  modport source (output valid, req_type, stroke_x_byte, stroke_y_byte, place_x, place_y,
                  input ready);
  modport sink   (input valid, req_type, stroke_x_byte, stroke_y_byte, place_x, place_y,
                  output ready);
endinterface

interface sgt_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         is_draw;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, is_draw, point_x, point_y, input ready);
  modport sink   (input valid, is_draw, point_x, point_y, output ready);
endinterface

interface sgt_cfg_if
  import sgt_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/stroke_glyph_transformer_core.sv]
// Stroke-font glyph transformer.
// in_if carries place items (set pen and rotation center) and stroke items
// (one byte pair of a stroke-font glyph). out_if carries one pen move or line
// draw per drawing stroke; place items and glyph ends produce no item.
// cfg_if writes the direction, scale, rotation enable, cosine and sine
// registers; it is always ready and must only be used while the block idles.
// Place items and glyph ends are handled as they are accepted. A drawing
// stroke steps through the scale, difference, rotation and emit states:
// one shared signed multiplier with an accumulator runs the two scale
// products and the four rotation products in turn, then truncation and
// clamp finish the point. in_if.ready is high only while the sequencer
// idles, so a new stroke is taken only once the last result is loaded. The
// result sits in an output register; a stalled receiver holds it and the
// next stroke may be computed meanwhile, waiting in its last step until the
// register frees. Synchronous active-low reset puts the registers at their
// reset values, pen, center and last step at zero, and drops valid.
`default_nettype none

module stroke_glyph_transformer_core
  import sgt_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  sgt_in_if.sink     in_if,
  sgt_out_if.source  out_if,
  sgt_cfg_if.sink    cfg_if
);

  localparam int C   = COORD_BITS;
  localparam int F   = SCALE_FRAC_BITS;
  localparam int SXW = 24;                 // scaled stroke offset
  localparam int DXW = C + F + 9;          // pen sum minus center
  localparam int MBW = TRIG_BITS + 1;      // multiplier b operand
  localparam int PRW = DXW + MBW;          // product
  localparam int AW  = DXW + 18;           // accumulator
  localparam int ROT_SHIFT = F + TRIG_FRAC_BITS;

  localparam logic signed [AW-1:0] CMAX_W = {{(AW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [AW-1:0] CMIN_W = {{(AW-C+1){1'b1}}, {(C-1){1'b0}}};

  function automatic logic signed [C-1:0] sat_w(input logic signed [AW-1:0] v);
    logic signed [C-1:0] r;
    if (v > CMAX_W) begin
      r = CMAX_W[C-1:0];
    end else if (v < CMIN_W) begin
      r = CMIN_W[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  // arithmetic shift right that truncates toward zero
  function automatic logic signed [AW-1:0] trunc_shift(input logic signed [AW-1:0] v,
                                                       input int unsigned k);
    logic signed [AW-1:0] q;
    logic        [AW-1:0] mask;
    mask = (AW'(1) << k) - AW'(1);
    q    = v >>> k;
    if (v[AW-1] && ((v & mask) != '0)) begin
      q = q + AW'(1);
    end
    return q;
  endfunction

  sgt_state_t state_r, state_nxt;

  // configuration
  logic                        text_direction_r;
  logic        [SCALE_BITS-1:0] scale_x_r, scale_y_r;
  logic                        rotate_enable_r;
  logic signed [TRIG_BITS-1:0] cos_angle_r, sin_angle_r;

  // architectural state
  logic signed [C-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic signed [C-1:0] center_x_r, center_x_nxt, center_y_r, center_y_nxt;
  logic signed [C-1:0] last_step_x_r, last_step_x_nxt, last_step_y_r, last_step_y_nxt;

  // datapath
  logic signed [7:0]     ox_r, ox_nxt, oy_r, oy_nxt;
  logic                  draw_r, draw_nxt;
  logic signed [SXW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DXW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic signed [C-1:0]   qx_r, qx_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_draw_r, out_draw_nxt;
  logic signed [C-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  // shared multiplier
  logic signed [DXW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [MBW-1:0] cos_eff, sin_eff;
  logic signed [7:0]     cx8, cy8;
  logic                  in_ready;

  assign prod    = PRW'(mul_a) * PRW'(mul_b);
  assign cos_eff = rotate_enable_r ? MBW'(cos_angle_r) : MBW'(TRIG_ONE);
  assign sin_eff = rotate_enable_r ? MBW'(sin_angle_r) : '0;
  assign cx8     = {in_if.stroke_x_byte[6], in_if.stroke_x_byte[6:0]};
  assign cy8     = {in_if.stroke_y_byte[6], in_if.stroke_y_byte[6:0]};

  assign in_if.ready    = in_ready;
  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.is_draw = out_draw_r;
  assign out_if.point_x = out_x_r;
  assign out_if.point_y = out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_direction_r <= 1'b0;
      scale_x_r        <= SCALE_RESET;
      scale_y_r        <= SCALE_RESET;
      rotate_enable_r  <= 1'b0;
      cos_angle_r      <= TRIG_ONE;
      sin_angle_r      <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_index_t'(cfg_if.index))
        CFG_TEXT_DIRECTION: text_direction_r <= cfg_if.data[0];
        CFG_SCALE_X:        scale_x_r        <= cfg_if.data;
        CFG_SCALE_Y:        scale_y_r        <= cfg_if.data;
        CFG_ROTATE_ENABLE:  rotate_enable_r  <= cfg_if.data[0];
        CFG_COS_ANGLE:      cos_angle_r      <= $signed(cfg_if.data);
        CFG_SIN_ANGLE:      sin_angle_r      <= $signed(cfg_if.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pen_x_r       <= '0;
      pen_y_r       <= '0;
      center_x_r    <= '0;
      center_y_r    <= '0;
      last_step_x_r <= '0;
      last_step_y_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pen_x_r       <= pen_x_nxt;
      pen_y_r       <= pen_y_nxt;
      center_x_r    <= center_x_nxt;
      center_y_r    <= center_y_nxt;
      last_step_x_r <= last_step_x_nxt;
      last_step_y_r <= last_step_y_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    draw_r     <= draw_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    acc_r      <= acc_nxt;
    qx_r       <= qx_nxt;
    out_draw_r <= out_draw_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    pen_x_nxt       = pen_x_r;
    pen_y_nxt       = pen_y_r;
    center_x_nxt    = center_x_r;
    center_y_nxt    = center_y_r;
    last_step_x_nxt = last_step_x_r;
    last_step_y_nxt = last_step_y_r;
    ox_nxt          = ox_r;
    oy_nxt          = oy_r;
    draw_nxt        = draw_r;
    sx_nxt          = sx_r;
    sy_nxt          = sy_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    acc_nxt         = acc_r;
    qx_nxt          = qx_r;
    out_draw_nxt    = out_draw_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    mul_a           = '0;
    mul_b           = '0;
    in_ready        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.req_type == REQ_PLACE) begin
            pen_x_nxt       = sat_w(AW'(in_if.place_x));
            pen_y_nxt       = sat_w(AW'(in_if.place_y));
            center_x_nxt    = sat_w(AW'(in_if.place_x));
            center_y_nxt    = sat_w(AW'(in_if.place_y));
            last_step_x_nxt = '0;
            last_step_y_nxt = '0;
          end else if (!in_if.stroke_x_byte[7]) begin
            // glyph end: advance by the last scaled offset
            pen_x_nxt       = sat_w(AW'(pen_x_r) + AW'(last_step_x_r));
            pen_y_nxt       = sat_w(AW'(pen_y_r) + AW'(last_step_y_r));
            last_step_x_nxt = '0;
            last_step_y_nxt = '0;
          end else begin
            if (text_direction_r) begin
              ox_nxt = -cy8;
              oy_nxt = -cx8;
            end else begin
              ox_nxt = cx8;
              oy_nxt = -cy8;
            end
            draw_nxt  = in_if.stroke_y_byte[7];
            state_nxt = ST_SCALE_X;
          end
        end
      end
      ST_SCALE_X: begin
        mul_a           = DXW'(ox_r);
        mul_b           = $signed({1'b0, scale_x_r});
        sx_nxt          = prod[SXW-1:0];
        last_step_x_nxt = sat_w(trunc_shift(AW'(prod), F));
        state_nxt       = ST_SCALE_Y;
      end
      ST_SCALE_Y: begin
        mul_a           = DXW'(oy_r);
        mul_b           = $signed({1'b0, scale_y_r});
        sy_nxt          = prod[SXW-1:0];
        last_step_y_nxt = sat_w(trunc_shift(AW'(prod), F));
        state_nxt       = ST_DIFF;
      end
      ST_DIFF: begin
        dx_nxt    = (DXW'(pen_x_r) <<< F) + DXW'(sx_r) - (DXW'(center_x_r) <<< F);
        dy_nxt    = (DXW'(pen_y_r) <<< F) + DXW'(sy_r) - (DXW'(center_y_r) <<< F);
        state_nxt = ST_ROT_X0;
      end
      ST_ROT_X0: begin
        mul_a     = dx_r;
        mul_b     = cos_eff;
        acc_nxt   = (AW'(center_x_r) <<< ROT_SHIFT) + AW'(prod);
        state_nxt = ST_ROT_X1;
      end
      ST_ROT_X1: begin
        mul_a     = dy_r;
        mul_b     = sin_eff;
        acc_nxt   = acc_r - AW'(prod);
        state_nxt = ST_ROT_Y0;
      end
      ST_ROT_Y0: begin
        mul_a     = dx_r;
        mul_b     = sin_eff;
        qx_nxt    = sat_w(trunc_shift(acc_r, ROT_SHIFT));
        acc_nxt   = (AW'(center_y_r) <<< ROT_SHIFT) + AW'(prod);
        state_nxt = ST_ROT_Y1;
      end
      ST_ROT_Y1: begin
        mul_a     = dy_r;
        mul_b     = cos_eff;
        acc_nxt   = acc_r + AW'(prod);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_draw_nxt  = draw_r;
          out_x_nxt     = qx_r;
          out_y_nxt     = sat_w(trunc_shift(acc_r, ROT_SHIFT));
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_stroke_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready && in_if.req_type == REQ_STROKE && in_if.stroke_x_byte[7])
      |=> (state_r == ST_SCALE_X))
    else $error("drawing stroke did not start the sequencer");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("finished stroke not presented on the output");

  a_place_sets_center: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready && in_if.req_type == REQ_PLACE)
      |=> (pen_x_r == center_x_r && pen_y_r == center_y_r && last_step_x_r == '0))
    else $error("place item left pen and center apart");

  a_glyph_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready && in_if.req_type == REQ_STROKE && !in_if.stroke_x_byte[7])
      |=> (last_step_x_r == '0 && last_step_y_r == '0 && state_r == ST_IDLE))
    else $error("glyph end did not clear the last step");

endmodule

`default_nettype wire

[tb/stroke_glyph_transformer_core_test.sv]
`timescale 1ns / 1ps

module stroke_glyph_transformer_core_test;
  import sgt_pkg::*;

  localparam int COORD_BITS      = 16;
  localparam int SCALE_FRAC_BITS = 8;
  localparam longint SCALE_ONE   = longint'(1) << SCALE_FRAC_BITS;
  localparam longint ROT_ONE     = longint'(1) << (SCALE_FRAC_BITS + TRIG_FRAC_BITS);
  localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam int TRIG_MAX        = 16384;
  localparam int STUCK_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 155;
  localparam int MAX_ERROR_LINES = 50;
  // indexes past the register list, written to check they are ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    req_type_t                         kind;
    logic        [STROKE_BYTE_BITS-1:0] x_byte;
    logic        [STROKE_BYTE_BITS-1:0] y_byte;
    logic signed [PLACE_BITS-1:0]       place_x;
    logic signed [PLACE_BITS-1:0]       place_y;
  } glyph_cmd_t;

  typedef struct {
    logic                         is_draw;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pen_point_t;

  logic clk;
  logic rst_n;

  sgt_in_if                             in_if ();
  sgt_out_if #(.COORD_BITS(COORD_BITS)) out_if ();
  sgt_cfg_if                            cfg_if ();

  stroke_glyph_transformer_core #(
    .COORD_BITS     (COORD_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor copy of the registers and the pen state
  logic                         dir_vertical;
  logic                         rot_on;
  logic [SCALE_BITS-1:0]        scl_x, scl_y;
  logic signed [TRIG_BITS-1:0]  cos_q, sin_q;
  logic signed [COORD_BITS-1:0] pen_x, pen_y, pivot_x, pivot_y, step_x, step_y;

  glyph_cmd_t cmd_backlog[$];
  pen_point_t pending_points[$];
  glyph_cmd_t on_bus;

  int send_idle_pct;
  int recv_stall_pct;
  int progress;
  int n_errors, n_checked, n_cfg, n_place, n_stroke, n_glyph_end;

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
    longint c;
    c = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
    return c[COORD_BITS-1:0];
  endfunction

  function automatic void reset_model();
    dir_vertical = 1'b0;
    rot_on       = 1'b0;
    scl_x        = SCALE_RESET;
    scl_y        = SCALE_RESET;
    cos_q        = TRIG_ONE;
    sin_q        = '0;
    pen_x        = '0;
    pen_y        = '0;
    pivot_x      = '0;
    pivot_y      = '0;
    step_x       = '0;
    step_y       = '0;
  endfunction

  function automatic void load_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      CFG_TEXT_DIRECTION: dir_vertical = val[0];
      CFG_SCALE_X:        scl_x = val;
      CFG_SCALE_Y:        scl_y = val;
      CFG_ROTATE_ENABLE:  rot_on = val[0];
      CFG_COS_ANGLE:      cos_q = val;
      CFG_SIN_ANGLE:      sin_q = val;
      default: ;
    endcase
  endfunction

  // advance the pen for one accepted item and queue the point it draws, if any
  function automatic void trace_pen(glyph_cmd_t c);
    longint cx, cy, ox, oy, sx, sy, px, py, dx, dy, rx, ry, qx, qy;
    pen_point_t pt;
    if (c.kind == REQ_PLACE) begin
      pen_x   = c.place_x;
      pen_y   = c.place_y;
      pivot_x = c.place_x;
      pivot_y = c.place_y;
      step_x  = '0;
      step_y  = '0;
      n_place++;
      return;
    end
    if (!c.x_byte[7]) begin
      pen_x  = clamp_coord(longint'(pen_x) + longint'(step_x));
      pen_y  = clamp_coord(longint'(pen_y) + longint'(step_y));
      step_x = '0;
      step_y = '0;
      n_glyph_end++;
      return;
    end
    n_stroke++;
    cx = $signed(c.x_byte[6:0]);
    cy = $signed(c.y_byte[6:0]);
    if (!dir_vertical) begin
      ox = cx;
      oy = -cy;
    end else begin
      ox = -cy;
      oy = -cx;
    end
    sx     = ox * longint'(scl_x);
    sy     = oy * longint'(scl_y);
    step_x = clamp_coord(sx / SCALE_ONE);
    step_y = clamp_coord(sy / SCALE_ONE);
    px     = longint'(pen_x) * SCALE_ONE + sx;
    py     = longint'(pen_y) * SCALE_ONE + sy;
    if (rot_on) begin
      dx = px - longint'(pivot_x) * SCALE_ONE;
      dy = py - longint'(pivot_y) * SCALE_ONE;
      rx = dx * longint'(cos_q) - dy * longint'(sin_q);
      ry = dx * longint'(sin_q) + dy * longint'(cos_q);
      qx = (longint'(pivot_x) * ROT_ONE + rx) / ROT_ONE;
      qy = (longint'(pivot_y) * ROT_ONE + ry) / ROT_ONE;
    end else begin
      qx = px / SCALE_ONE;
      qy = py / SCALE_ONE;
    end
    pt.is_draw = c.y_byte[7];
    pt.x       = clamp_coord(qx);
    pt.y       = clamp_coord(qy);
    pending_points.push_back(pt);
  endfunction

  task automatic flag_error(string msg);
    n_errors++;
    if (n_errors <= MAX_ERROR_LINES)
      $display("[%0t] error: %s", $time, msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        trace_pen(on_bus);
        progress++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus               = cmd_backlog.pop_front();
          in_if.valid         <= 1'b1;
          in_if.req_type      <= on_bus.kind;
          in_if.stroke_x_byte <= on_bus.x_byte;
          in_if.stroke_y_byte <= on_bus.y_byte;
          in_if.place_x       <= on_bus.place_x;
          in_if.place_y       <= on_bus.place_y;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : point_monitor
    pen_point_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        progress++;
        if (pending_points.size() == 0) begin
          flag_error($sformatf("unexpected point draw=%0b x=%0d y=%0d",
                               out_if.is_draw, out_if.point_x, out_if.point_y));
        end else begin
          want = pending_points.pop_front();
          n_checked++;
          if (out_if.is_draw !== want.is_draw)
            flag_error($sformatf("is_draw got %0b want %0b", out_if.is_draw, want.is_draw));
          if (out_if.point_x !== want.x)
            flag_error($sformatf("point_x got %0d want %0d", out_if.point_x, want.x));
          if (out_if.point_y !== want.y)
            flag_error($sformatf("point_y got %0d want %0d", out_if.point_y, want.y));
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    load_reg(idx, val);
    n_cfg++;
    progress++;
  endtask

  function automatic glyph_cmd_t make_cmd(req_type_t k, logic [7:0] xb, logic [7:0] yb,
                                          logic [15:0] plx, logic [15:0] ply);
    glyph_cmd_t c;
    c.kind    = k;
    c.x_byte  = xb;
    c.y_byte  = yb;
    c.place_x = plx;
    c.place_y = ply;
    return c;
  endfunction

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return 16'($urandom_range(65535));
  endfunction

  // mostly well-formed glyphs with random content, some noise and unfinished glyphs
  task automatic queue_random(int count);
    int added;
    int n;
    added = 0;
    while (added < count) begin
      if ($urandom_range(9) == 0) begin
        cmd_backlog.push_back(make_cmd(req_type_t'($urandom_range(1)),
                                       8'($urandom_range(255)), 8'($urandom_range(255)),
                                       rand_coord(), rand_coord()));
        added++;
      end else begin
        if ($urandom_range(2) == 0) begin
          cmd_backlog.push_back(make_cmd(REQ_PLACE, 8'($urandom_range(255)),
                                         8'($urandom_range(255)), rand_coord(), rand_coord()));
          added++;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          cmd_backlog.push_back(make_cmd(REQ_STROKE, {1'b1, 7'($urandom_range(127))},
                                         8'($urandom_range(255)), rand_coord(), rand_coord()));
          added++;
        end
        if ($urandom_range(7) != 0) begin
          cmd_backlog.push_back(make_cmd(REQ_STROKE, {1'b0, 7'($urandom_range(127))},
                                         8'($urandom_range(255)), rand_coord(), rand_coord()));
          added++;
        end
      end
    end
  endtask

  task automatic setup_phase(int ph);
    logic        dir, rot;
    logic [15:0] sx, sy;
    int          c, s;
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    case (ph)
      0: begin dir = 1'b1; sx = 16'd0;     sy = 16'hffff; rot = 1'b1; c = TRIG_MAX;  s = -TRIG_MAX; end
      1: begin dir = 1'b0; sx = 16'hffff;  sy = 16'd0;    rot = 1'b1; c = -TRIG_MAX; s = TRIG_MAX;  end
      2: begin dir = 1'b1; sx = SCALE_RESET; sy = SCALE_RESET; rot = 1'b0;
               c = -TRIG_MAX; s = -TRIG_MAX; end
      3: begin dir = 1'b0; sx = 16'd1;     sy = 16'd1;    rot = 1'b1; c = 0;         s = TRIG_MAX;  end
      default: begin
        dir = 1'($urandom_range(1));
        rot = 1'($urandom_range(1));
        sx  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1023));
        sy  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1023));
        c   = int'($urandom_range(2 * TRIG_MAX)) - TRIG_MAX;
        s   = int'($urandom_range(2 * TRIG_MAX)) - TRIG_MAX;
      end
    endcase
    write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom_range(65535)));
    write_reg(CFG_TEXT_DIRECTION, {15'd0, dir});
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    write_reg(CFG_ROTATE_ENABLE, {15'd0, rot});
    write_reg(CFG_COS_ANGLE, CFG_DATA_BITS'(c));
    write_reg(CFG_SIN_ANGLE, CFG_DATA_BITS'(s));
  endtask

  // hold until every item is taken and every point has come out, then let the block settle
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_if.valid || pending_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : watchdog
    int stuck;
    int seen;
    stuck = 0;
    seen  = 0;
    while (stuck < STUCK_LIMIT) begin
      @(negedge clk);
      if (progress != seen) begin
        seen  = progress;
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int ph;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.req_type      = REQ_PLACE;
    in_if.stroke_x_byte = '0;
    in_if.stroke_y_byte = '0;
    in_if.place_x       = '0;
    in_if.place_y       = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_TEXT_DIRECTION;
    cfg_if.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    progress            = 0;
    n_errors            = 0;
    n_checked           = 0;
    n_cfg               = 0;
    n_place             = 0;
    n_stroke            = 0;
    n_glyph_end         = 0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on the reset settings: empty glyph, byte extremes, pen saturation
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h00, 8'hff, 16'h7fff, 16'h8000));
    cmd_backlog.push_back(make_cmd(REQ_PLACE,  8'hff, 8'hff, 16'h7fff, 16'h7fff));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'hbf, 8'hc0, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'hc0, 8'h3f, 16'hffff, 16'hffff));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h7f, 8'h80, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h81, 8'h81, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_PLACE,  8'h00, 8'h00, 16'h8000, 16'h8000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'hc0, 8'hbf, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h00, 8'h00, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_PLACE,  8'h80, 8'h80, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h80, 8'h00, 16'h7fff, 16'h8000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'hff, 8'hff, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h40, 8'h7f, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h00, 8'h00, 16'h0000, 16'h0000));
    cmd_backlog.push_back(make_cmd(REQ_STROKE, 8'h90, 8'h70, 16'h1234, 16'hedcb));
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      setup_phase(ph);
      @(negedge clk);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    $display("ran %0d items: %0d place, %0d stroke, %0d glyph end",
             n_place + n_stroke + n_glyph_end, n_place, n_stroke, n_glyph_end);
    $display("checked %0d points over %0d register writes in %0d settings",
             n_checked, n_cfg, NUM_PHASES + 1);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
